### design/tbu_pkg.sv
// tbu_pkg: types and constants shared by the thumb branch unit
// no dependencies; used by every module of the block, not by the interfaces
`timescale 1ns / 1ps

package tbu_pkg;

    typedef enum logic [2:0] {
        OP_BX        = 3'd0,
        OP_B_COND    = 3'd1,
        OP_B         = 3'd2,
        OP_BL_PREFIX = 3'd3,
        OP_BL_SUFFIX = 3'd4,
        OP_SWI       = 3'd5,
        OP_UNDEF     = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        EXC_NONE = 2'd0,
        EXC_SWI  = 2'd1,
        EXC_UND  = 2'd2
    } t_exc;

    typedef enum logic [3:0] {
        COND_EQ = 4'd0,
        COND_NE = 4'd1,
        COND_CS = 4'd2,
        COND_CC = 4'd3,
        COND_MI = 4'd4,
        COND_PL = 4'd5,
        COND_VS = 4'd6,
        COND_VC = 4'd7,
        COND_HI = 4'd8,
        COND_LS = 4'd9,
        COND_GE = 4'd10,
        COND_LT = 4'd11,
        COND_GT = 4'd12,
        COND_LE = 4'd13,
        COND_AL = 4'd14,
        COND_NV = 4'd15
    } t_cond;

    localparam logic [1:0] CYC_BL_PREFIX = 2'd1;
    localparam logic [1:0] CYC_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]         op;
        logic [31:0]        cur_pc;
        logic [31:0]        reg_value;
        logic signed [22:0] offset;
        logic [3:0]         cond_code;
        logic [3:0]         flags_nzcv;
        logic [31:0]        cur_lr;
    } t_in_item;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        pc_write;
        logic [31:0] next_lr;
        logic        lr_write;
        logic        thumb_bit;
        logic        thumb_write;
        t_exc        exception_kind;
        logic [31:0] return_address;
        logic [1:0]  cycle_count;
    } t_result;

endpackage

### design/tbu_if.sv
// tbu_in_if and tbu_out_if: valid/ready channels of the thumb branch unit
// depends on tbu_pkg for nothing but sits after it in compile order
`timescale 1ns / 1ps

interface tbu_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic [31:0]        cur_pc;
    logic [31:0]        reg_value;
    logic signed [22:0] offset;
    logic [3:0]         cond_code;
    logic [3:0]         flags_nzcv;
    logic [31:0]        cur_lr;

    modport source (output valid, op, cur_pc, reg_value, offset, cond_code,
                    flags_nzcv, cur_lr, input ready);
    modport sink   (input valid, op, cur_pc, reg_value, offset, cond_code,
                    flags_nzcv, cur_lr, output ready);
endinterface

interface tbu_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic        pc_write;
    logic [31:0] next_lr;
    logic        lr_write;
    logic        thumb_bit;
    logic        thumb_write;
    logic [1:0]  exception_kind;
    logic [31:0] return_address;
    logic [1:0]  cycle_count;

    modport source (output valid, next_pc, pc_write, next_lr, lr_write, thumb_bit,
                    thumb_write, exception_kind, return_address, cycle_count,
                    input ready);
    modport sink   (input valid, next_pc, pc_write, next_lr, lr_write, thumb_bit,
                    thumb_write, exception_kind, return_address, cycle_count,
                    output ready);
endinterface

### design/tbu_cond.sv
// tbu_cond: arm condition code check against the nzcv flags
// depends on tbu_pkg (t_cond)
`timescale 1ns / 1ps

module tbu_cond (
    input  logic [3:0] i_cond_code,
    input  logic [3:0] i_flags_nzcv,
    output logic       o_holds
);

    logic n, z, c, v;

    assign n = i_flags_nzcv[3];
    assign z = i_flags_nzcv[2];
    assign c = i_flags_nzcv[1];
    assign v = i_flags_nzcv[0];

    always_comb begin
        unique case (tbu_pkg::t_cond'(i_cond_code))
            tbu_pkg::COND_EQ: o_holds = z;
            tbu_pkg::COND_NE: o_holds = !z;
            tbu_pkg::COND_CS: o_holds = c;
            tbu_pkg::COND_CC: o_holds = !c;
            tbu_pkg::COND_MI: o_holds = n;
            tbu_pkg::COND_PL: o_holds = !n;
            tbu_pkg::COND_VS: o_holds = v;
            tbu_pkg::COND_VC: o_holds = !v;
            tbu_pkg::COND_HI: o_holds = c && !z;
            tbu_pkg::COND_LS: o_holds = !c || z;
            tbu_pkg::COND_GE: o_holds = (n == v);
            tbu_pkg::COND_LT: o_holds = (n != v);
            tbu_pkg::COND_GT: o_holds = !z && (n == v);
            tbu_pkg::COND_LE: o_holds = z || (n != v);
            tbu_pkg::COND_AL: o_holds = 1'b1;
            tbu_pkg::COND_NV: o_holds = 1'b0;
            default:          o_holds = 1'b0;
        endcase
    end

endmodule

### design/tbu_exec.sv
// tbu_exec: combinational execute of one decoded thumb control-flow op
// depends on tbu_pkg (t_in_item, t_result, codes) and tbu_cond
`timescale 1ns / 1ps

module tbu_exec (
    input  tbu_pkg::t_in_item i_item,
    input  logic              i_single_step,
    output tbu_pkg::t_result  o_result
);

    logic        cond_ok;
    logic [31:0] off32;
    logic [31:0] br_target;
    logic [31:0] bl_target;
    logic [31:0] ret_addr;

    tbu_cond u_cond (
        .i_cond_code  (i_item.cond_code),
        .i_flags_nzcv (i_item.flags_nzcv),
        .o_holds      (cond_ok)
    );

    assign off32     = {{9{i_item.offset[22]}}, i_item.offset};
    assign br_target = i_item.cur_pc + 32'd2 + off32;
    assign bl_target = i_item.cur_lr + off32;
    assign ret_addr  = i_item.cur_pc - 32'd2;

    always_comb begin
        o_result                = '0;
        o_result.exception_kind = tbu_pkg::EXC_NONE;
        o_result.cycle_count    = tbu_pkg::CYC_FULL;
        unique case (tbu_pkg::t_op'(i_item.op))
            tbu_pkg::OP_BX: begin
                o_result.thumb_write = 1'b1;
                o_result.pc_write    = 1'b1;
                if (i_item.reg_value[0]) begin
                    o_result.thumb_bit = 1'b1;
                    o_result.next_pc   = {i_item.reg_value[31:1], 1'b0}
                                         + (i_single_step ? 32'd2 : 32'd0);
                end else if (i_single_step) begin
                    o_result.next_pc = (i_item.reg_value + 32'd6) & ~32'd1;
                end else begin
                    o_result.next_pc = {i_item.reg_value[31:2], 2'b00};
                end
            end
            tbu_pkg::OP_B_COND: begin
                if (cond_ok) begin
                    o_result.pc_write = 1'b1;
                    o_result.next_pc  = br_target;
                end
            end
            tbu_pkg::OP_B: begin
                o_result.pc_write = 1'b1;
                o_result.next_pc  = br_target;
            end
            tbu_pkg::OP_BL_PREFIX: begin
                o_result.lr_write    = 1'b1;
                o_result.next_lr     = i_item.cur_pc + off32
                                       + (i_single_step ? 32'd0 : 32'd2);
                o_result.cycle_count = tbu_pkg::CYC_BL_PREFIX;
            end
            tbu_pkg::OP_BL_SUFFIX: begin
                o_result.lr_write = 1'b1;
                o_result.pc_write = 1'b1;
                if (i_single_step) begin
                    o_result.next_lr = ret_addr | 32'd1;
                    o_result.next_pc = (bl_target + 32'd2) & ~32'd1;
                end else begin
                    o_result.next_lr = i_item.cur_pc | 32'd1;
                    o_result.next_pc = {bl_target[31:1], 1'b0};
                end
            end
            tbu_pkg::OP_SWI: begin
                o_result.exception_kind = tbu_pkg::EXC_SWI;
                o_result.return_address = ret_addr;
            end
            default: begin
                // undefined op and the unused encoding
                o_result.exception_kind = tbu_pkg::EXC_UND;
                o_result.return_address = ret_addr;
            end
        endcase
    end

endmodule

### design/thumb_branch_unit.sv
// thumb_branch_unit: input register, execute logic, result register
// an accepted input beat is registered in the input stage, its result in the result register
// throughput: one beat per cycle while results are taken; a full result register stalls the input register
// reset: synchronous active-low i_rst_n empties both stages and clears single-step mode
// depends on tbu_pkg, tbu_in_if, tbu_out_if, tbu_exec
`timescale 1ns / 1ps

module thumb_branch_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    tbu_in_if.sink     i_item,
    tbu_out_if.source  o_result
);

    logic              r_single_step;
    logic              r_s1_valid;
    tbu_pkg::t_in_item r_s1;
    logic              r_out_valid;
    tbu_pkg::t_result  r_out;

    tbu_pkg::t_in_item in_item;
    tbu_pkg::t_result  exec_result;
    logic              out_free;
    logic              s1_free;

    assign out_free     = !r_out_valid || o_result.ready;
    assign s1_free      = !r_s1_valid || out_free;
    assign i_item.ready = s1_free;

    assign in_item.op         = i_item.op;
    assign in_item.cur_pc     = i_item.cur_pc;
    assign in_item.reg_value  = i_item.reg_value;
    assign in_item.offset     = i_item.offset;
    assign in_item.cond_code  = i_item.cond_code;
    assign in_item.flags_nzcv = i_item.flags_nzcv;
    assign in_item.cur_lr     = i_item.cur_lr;

    tbu_exec u_exec (
        .i_item        (r_s1),
        .i_single_step (r_single_step),
        .o_result      (exec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_single_step <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_single_step <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_item.valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_item.valid) begin
            r_s1 <= in_item;
        end
        if (out_free && r_s1_valid) begin
            r_out <= exec_result;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.next_pc        = r_out.next_pc;
    assign o_result.pc_write       = r_out.pc_write;
    assign o_result.next_lr        = r_out.next_lr;
    assign o_result.lr_write       = r_out.lr_write;
    assign o_result.thumb_bit      = r_out.thumb_bit;
    assign o_result.thumb_write    = r_out.thumb_write;
    assign o_result.exception_kind = r_out.exception_kind;
    assign o_result.return_address = r_out.return_address;
    assign o_result.cycle_count    = r_out.cycle_count;

    // a beat held in the input stage survives a stall unchanged
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> (r_s1_valid && $stable(r_s1)))
        else $error("input stage lost or changed a stalled beat");

    // a new result beat only comes from a filled input stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && $past(out_free)) |-> $past(r_s1_valid))
        else $error("result beat appeared without an input beat");

    // a pc write never comes with an exception request
    a_pc_exc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.pc_write && (r_out.exception_kind != tbu_pkg::EXC_NONE)))
        else $error("pc write together with an exception");

    // the short cycle count belongs to the bl prefix alone
    a_cyc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.cycle_count == tbu_pkg::CYC_BL_PREFIX)
                         == (r_out.lr_write && !r_out.pc_write)))
        else $error("cycle count does not match the operation");

endmodule

### tb/tb_top.sv
// tb_top: self-checking bench for thumb_branch_unit, a directed table then random branches
// depends on tbu_pkg, tbu_in_if, tbu_out_if and the thumb_branch_unit rtl
`timescale 1ns / 1ps

module tb_top;

    localparam logic [2:0] OP_UNUSED   = 3'd7;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         PHASES      = 8;
    localparam int         PHASE_LEN   = 250;

    typedef struct {
        bit                ss;
        tbu_pkg::t_in_item stim;
        bit                typed;
        tbu_pkg::t_result  want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    tbu_in_if  in_if ();
    tbu_out_if out_if ();

    thumb_branch_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_item        (in_if),
        .o_result      (out_if)
    );

    always #1 i_clk = ~i_clk;

    tbu_pkg::t_result pending_outcomes[$];
    t_dir_row         dir_rows[$];
    logic             step_mode = 1'b0;
    bit               tx_quiet = 1'b0;
    bit               rx_quiet = 1'b0;
    int               rx_hold_cycles = 0;
    int               mismatches = 0;
    int               instr_count = 0;
    int               outcome_count = 0;
    int               bl_pairs = 0;
    int               cfg_writes = 0;
    int               cycles = 0;

    function automatic bit cond_passes(logic [3:0] cc, logic [3:0] nzcv);
        logic n, z, c, v;
        {n, z, c, v} = nzcv;
        case (cc)
            tbu_pkg::COND_EQ: return z;
            tbu_pkg::COND_NE: return !z;
            tbu_pkg::COND_CS: return c;
            tbu_pkg::COND_CC: return !c;
            tbu_pkg::COND_MI: return n;
            tbu_pkg::COND_PL: return !n;
            tbu_pkg::COND_VS: return v;
            tbu_pkg::COND_VC: return !v;
            tbu_pkg::COND_HI: return c && !z;
            tbu_pkg::COND_LS: return !c || z;
            tbu_pkg::COND_GE: return n == v;
            tbu_pkg::COND_LT: return n != v;
            tbu_pkg::COND_GT: return !z && (n == v);
            tbu_pkg::COND_LE: return z || (n != v);
            tbu_pkg::COND_AL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic tbu_pkg::t_result branch_outcome(tbu_pkg::t_in_item it, logic ss);
        tbu_pkg::t_result r;
        logic [31:0]      off32;
        logic [31:0]      tgt;
        r = '0;
        r.exception_kind = tbu_pkg::EXC_NONE;
        r.cycle_count = tbu_pkg::CYC_FULL;
        off32 = {{9{it.offset[22]}}, it.offset};
        case (it.op)
            tbu_pkg::OP_BX: begin
                r.pc_write = 1'b1;
                r.thumb_write = 1'b1;
                if (it.reg_value[0]) begin
                    r.thumb_bit = 1'b1;
                    r.next_pc = (it.reg_value & ~32'd1) + (ss ? 32'd2 : 32'd0);
                end else begin
                    r.next_pc = ss ? ((it.reg_value + 32'd6) & ~32'd1)
                                   : (it.reg_value & ~32'd3);
                end
            end
            tbu_pkg::OP_B_COND: begin
                if (cond_passes(it.cond_code, it.flags_nzcv)) begin
                    r.pc_write = 1'b1;
                    r.next_pc = it.cur_pc + 32'd2 + off32;
                end
            end
            tbu_pkg::OP_B: begin
                r.pc_write = 1'b1;
                r.next_pc = it.cur_pc + 32'd2 + off32;
            end
            tbu_pkg::OP_BL_PREFIX: begin
                r.lr_write = 1'b1;
                r.next_lr = it.cur_pc + (ss ? 32'd0 : 32'd2) + off32;
                r.cycle_count = tbu_pkg::CYC_BL_PREFIX;
            end
            tbu_pkg::OP_BL_SUFFIX: begin
                tgt = it.cur_lr + off32;
                r.lr_write = 1'b1;
                r.pc_write = 1'b1;
                if (ss) begin
                    r.next_lr = (it.cur_pc - 32'd2) | 32'd1;
                    r.next_pc = (tgt + 32'd2) & ~32'd1;
                end else begin
                    r.next_lr = it.cur_pc | 32'd1;
                    r.next_pc = tgt & ~32'd1;
                end
            end
            tbu_pkg::OP_SWI: begin
                r.exception_kind = tbu_pkg::EXC_SWI;
                r.return_address = it.cur_pc - 32'd2;
            end
            default: begin
                // opcode seven lands here as well
                r.exception_kind = tbu_pkg::EXC_UND;
                r.return_address = it.cur_pc - 32'd2;
            end
        endcase
        return r;
    endfunction

    function automatic tbu_pkg::t_in_item mk_instr(logic [2:0] op, logic [31:0] pc,
                                                   logic [31:0] rv, logic [22:0] off,
                                                   logic [3:0] cc, logic [3:0] fl,
                                                   logic [31:0] lr);
        tbu_pkg::t_in_item it;
        it.op = op;
        it.cur_pc = pc;
        it.reg_value = rv;
        it.offset = off;
        it.cond_code = cc;
        it.flags_nzcv = fl;
        it.cur_lr = lr;
        return it;
    endfunction

    function automatic tbu_pkg::t_result mk_outcome(logic [31:0] npc, logic pcw,
                                                    logic [31:0] nlr, logic lrw, logic tb,
                                                    logic tw, tbu_pkg::t_exc exc,
                                                    logic [31:0] ret, logic [1:0] cyc);
        tbu_pkg::t_result r;
        r.next_pc = npc;
        r.pc_write = pcw;
        r.next_lr = nlr;
        r.lr_write = lrw;
        r.thumb_bit = tb;
        r.thumb_write = tw;
        r.exception_kind = exc;
        r.return_address = ret;
        r.cycle_count = cyc;
        return r;
    endfunction

    // mostly uniform words, with the wrap corners mixed in
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 23))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'hFFFF_FFFE;
            3: return 32'h8000_0000;
            4: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic tbu_pkg::t_in_item rand_instr();
        tbu_pkg::t_in_item it;
        it.op = ($urandom_range(0, 15) == 0) ? OP_UNUSED
              : 3'($urandom_range(tbu_pkg::OP_BX, tbu_pkg::OP_UNDEF));
        it.cur_pc = rand_word();
        it.reg_value = rand_word();
        case ($urandom_range(0, 15))
            0: it.offset = 23'h3F_FFFF;
            1: it.offset = 23'h40_0000;
            default: it.offset = 23'($urandom);
        endcase
        it.cond_code = 4'($urandom_range(tbu_pkg::COND_EQ, tbu_pkg::COND_NV));
        it.flags_nzcv = 4'($urandom_range(0, 15));
        it.cur_lr = rand_word();
        return it;
    endfunction

    function automatic int tx_gap();
        return tx_quiet ? 0 : $urandom_range(0, 9);
    endfunction

    task automatic add_row(bit ss, tbu_pkg::t_in_item stim, bit typed, tbu_pkg::t_result want);
        t_dir_row row;
        row.ss = ss;
        row.stim = stim;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    // called just after a rising edge; valid stays up between back-to-back beats
    task automatic send_instr(tbu_pkg::t_in_item it, bit typed, tbu_pkg::t_result want);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.op <= it.op;
        in_if.cur_pc <= it.cur_pc;
        in_if.reg_value <= it.reg_value;
        in_if.offset <= it.offset;
        in_if.cond_code <= it.cond_code;
        in_if.flags_nzcv <= it.flags_nzcv;
        in_if.cur_lr <= it.cur_lr;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        pending_outcomes.push_back(typed ? want : branch_outcome(it, step_mode));
        instr_count++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_step_mode(logic mode);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge i_clk);
        step_mode = mode;
        cfg_writes++;
        cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cmp_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_outcomes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        tbu_pkg::t_result want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            outcome_count++;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, actual pc %h lr %h exc %h",
                         $time, out_if.next_pc, out_if.next_lr, out_if.exception_kind);
            end else begin
                want = pending_outcomes.pop_front();
                cmp_field("next_pc", want.next_pc, out_if.next_pc);
                cmp_field("pc_write", 32'(want.pc_write), 32'(out_if.pc_write));
                cmp_field("next_lr", want.next_lr, out_if.next_lr);
                cmp_field("lr_write", 32'(want.lr_write), 32'(out_if.lr_write));
                cmp_field("thumb_bit", 32'(want.thumb_bit), 32'(out_if.thumb_bit));
                cmp_field("thumb_write", 32'(want.thumb_write), 32'(out_if.thumb_write));
                cmp_field("exception_kind", 32'(want.exception_kind),
                          32'(out_if.exception_kind));
                cmp_field("return_address", want.return_address, out_if.return_address);
                cmp_field("cycle_count", 32'(want.cycle_count), 32'(out_if.cycle_count));
            end
        end
    end

    // result sink with random back-pressure and one long hold-off on request
    initial begin : result_sink
        int stall;
        int beats;
        beats = 0;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (beats % 40 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            stall = rx_quiet ? 0 : $urandom_range(0, 9);
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid === 1'b1 && out_if.ready === 1'b1));
            beats++;
        end
    end

    initial begin : stimulus
        tbu_pkg::t_in_item pre;
        tbu_pkg::t_in_item suf;
        tbu_pkg::t_result  pre_out;
        int                n;
        i_rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.op <= tbu_pkg::OP_BX;
        in_if.cur_pc <= '0;
        in_if.reg_value <= '0;
        in_if.offset <= '0;
        in_if.cond_code <= tbu_pkg::COND_EQ;
        in_if.flags_nzcv <= '0;
        in_if.cur_lr <= '0;

        // step mode 0 after reset, then the single-step conventions
        add_row(1'b0, mk_instr(tbu_pkg::OP_BX, 32'h0, 32'hFFFF_FFFF, 23'h0, tbu_pkg::COND_EQ,
                               4'h0, 32'h0), 1'b1,
                mk_outcome(32'hFFFF_FFFE, 1'b1, 32'h0, 1'b0, 1'b1, 1'b1, tbu_pkg::EXC_NONE,
                           32'h0, tbu_pkg::CYC_FULL));
        add_row(1'b0, mk_instr(tbu_pkg::OP_BX, 32'h0, 32'h0000_0002, 23'h0, tbu_pkg::COND_EQ,
                               4'h0, 32'h0), 1'b1,
                mk_outcome(32'h0, 1'b1, 32'h0, 1'b0, 1'b0, 1'b1, tbu_pkg::EXC_NONE,
                           32'h0, tbu_pkg::CYC_FULL));
        add_row(1'b0, mk_instr(tbu_pkg::OP_B_COND, 32'h100, 32'h0, 23'h10, tbu_pkg::COND_NV,
                               4'hF, 32'h0), 1'b1,
                mk_outcome(32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, tbu_pkg::EXC_NONE,
                           32'h0, tbu_pkg::CYC_FULL));
        add_row(1'b0, mk_instr(tbu_pkg::OP_B_COND, 32'h100, 32'h0, 23'h0, tbu_pkg::COND_AL,
                               4'h0, 32'h0), 1'b1,
                mk_outcome(32'h102, 1'b1, 32'h0, 1'b0, 1'b0, 1'b0, tbu_pkg::EXC_NONE,
                           32'h0, tbu_pkg::CYC_FULL));
        add_row(1'b0, mk_instr(tbu_pkg::OP_B_COND, 32'h200, 32'h0, 23'h40, tbu_pkg::COND_EQ,
                               4'h4, 32'h0), 1'b0, '0);
        add_row(1'b0, mk_instr(tbu_pkg::OP_B_COND, 32'h200, 32'h0, 23'h40, tbu_pkg::COND_NE,
                               4'h4, 32'h0), 1'b0, '0);
        add_row(1'b0, mk_instr(tbu_pkg::OP_B_COND, 32'h200, 32'h0, 23'h7F_FFC0,
                               tbu_pkg::COND_HI, 4'h2, 32'h0), 1'b0, '0);
        add_row(1'b0, mk_instr(tbu_pkg::OP_B_COND, 32'h300, 32'h0, 23'h8, tbu_pkg::COND_GE,
                               4'h9, 32'h0), 1'b0, '0);
        add_row(1'b0, mk_instr(tbu_pkg::OP_B_COND, 32'h300, 32'h0, 23'h8, tbu_pkg::COND_LE,
                               4'h8, 32'h0), 1'b0, '0);
        add_row(1'b0, mk_instr(tbu_pkg::OP_B, 32'hFFFF_FFFE, 32'h0, 23'h0, tbu_pkg::COND_EQ,
                               4'h0, 32'h0), 1'b1,
                mk_outcome(32'h0, 1'b1, 32'h0, 1'b0, 1'b0, 1'b0, tbu_pkg::EXC_NONE,
                           32'h0, tbu_pkg::CYC_FULL));
        add_row(1'b0, mk_instr(tbu_pkg::OP_B, 32'h0, 32'h0, 23'h3F_FFFF, tbu_pkg::COND_EQ,
                               4'h0, 32'h0), 1'b1,
                mk_outcome(32'h0040_0001, 1'b1, 32'h0, 1'b0, 1'b0, 1'b0, tbu_pkg::EXC_NONE,
                           32'h0, tbu_pkg::CYC_FULL));
        add_row(1'b0, mk_instr(tbu_pkg::OP_B, 32'h0, 32'h0, 23'h40_0000, tbu_pkg::COND_EQ,
                               4'h0, 32'h0), 1'b1,
                mk_outcome(32'hFFC0_0002, 1'b1, 32'h0, 1'b0, 1'b0, 1'b0, tbu_pkg::EXC_NONE,
                           32'h0, tbu_pkg::CYC_FULL));
        add_row(1'b0, mk_instr(tbu_pkg::OP_BL_PREFIX, 32'h1000, 32'h0, 23'h7F_FFFF,
                               tbu_pkg::COND_EQ, 4'h0, 32'h0), 1'b0, '0);
        add_row(1'b0, mk_instr(tbu_pkg::OP_BL_SUFFIX, 32'h2000, 32'h0, 23'h10,
                               tbu_pkg::COND_EQ, 4'h0, 32'h8001), 1'b0, '0);
        add_row(1'b0, mk_instr(tbu_pkg::OP_SWI, 32'h0, 32'h0, 23'h0, tbu_pkg::COND_EQ,
                               4'h0, 32'h0), 1'b1,
                mk_outcome(32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, tbu_pkg::EXC_SWI,
                           32'hFFFF_FFFE, tbu_pkg::CYC_FULL));
        add_row(1'b0, mk_instr(tbu_pkg::OP_UNDEF, 32'h1234, 32'h0, 23'h0, tbu_pkg::COND_EQ,
                               4'h0, 32'h0), 1'b1,
                mk_outcome(32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, tbu_pkg::EXC_UND,
                           32'h1232, tbu_pkg::CYC_FULL));
        add_row(1'b0, mk_instr(OP_UNUSED, 32'h2, 32'h0, 23'h0, tbu_pkg::COND_EQ,
                               4'h0, 32'h0), 1'b1,
                mk_outcome(32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, tbu_pkg::EXC_UND,
                           32'h0, tbu_pkg::CYC_FULL));
        add_row(1'b0, mk_instr(tbu_pkg::OP_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 23'h7F_FFFF,
                               tbu_pkg::COND_NV, 4'hF, 32'hFFFF_FFFF), 1'b1,
                mk_outcome(32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, tbu_pkg::EXC_UND,
                           32'hFFFF_FFFD, tbu_pkg::CYC_FULL));
        add_row(1'b1, mk_instr(tbu_pkg::OP_BX, 32'h0, 32'h0000_0101, 23'h0, tbu_pkg::COND_EQ,
                               4'h0, 32'h0), 1'b0, '0);
        add_row(1'b1, mk_instr(tbu_pkg::OP_BX, 32'h0, 32'hFFFF_FFFC, 23'h0, tbu_pkg::COND_EQ,
                               4'h0, 32'h0), 1'b0, '0);
        add_row(1'b1, mk_instr(tbu_pkg::OP_BX, 32'h0, 32'hFFFF_FFFF, 23'h0, tbu_pkg::COND_EQ,
                               4'h0, 32'h0), 1'b0, '0);
        add_row(1'b1, mk_instr(tbu_pkg::OP_BL_PREFIX, 32'h1000, 32'h0, 23'h20,
                               tbu_pkg::COND_EQ, 4'h0, 32'h0), 1'b0, '0);
        add_row(1'b1, mk_instr(tbu_pkg::OP_BL_SUFFIX, 32'h0, 32'h0, 23'h1, tbu_pkg::COND_EQ,
                               4'h0, 32'hFFFF_FFFF), 1'b0, '0);
        add_row(1'b1, mk_instr(tbu_pkg::OP_B, 32'h10, 32'h0, 23'h7F_FFF0, tbu_pkg::COND_EQ,
                               4'h0, 32'h0), 1'b0, '0);
        add_row(1'b1, mk_instr(tbu_pkg::OP_B_COND, 32'h40, 32'h0, 23'h20, tbu_pkg::COND_VS,
                               4'h1, 32'h0), 1'b0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].ss != step_mode)
                set_step_mode(dir_rows[i].ss);
            send_instr(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            set_step_mode(p[0]);
            // one phase fills the block behind a long sink hold-off
            if (p == 3)
                rx_hold_cycles = 60;
            n = 0;
            while (n < PHASE_LEN) begin
                if (n % 40 == 0)
                    tx_quiet = ($urandom_range(0, 3) == 0) || (p == 3 && n < 80);
                if ($urandom_range(0, 4) == 0) begin
                    // linked pair: suffix reads the lr that the prefix produced
                    pre = rand_instr();
                    pre.op = tbu_pkg::OP_BL_PREFIX;
                    pre_out = branch_outcome(pre, step_mode);
                    suf = rand_instr();
                    suf.op = tbu_pkg::OP_BL_SUFFIX;
                    suf.cur_pc = pre.cur_pc + 32'd2;
                    suf.cur_lr = pre_out.next_lr;
                    send_instr(pre, 1'b0, '0);
                    send_instr(suf, 1'b0, '0);
                    bl_pairs++;
                    n += 2;
                end else begin
                    send_instr(rand_instr(), 1'b0, '0);
                    n++;
                end
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("%0d branch instructions sent (%0d linked bl pairs), %0d step-mode writes",
                 instr_count, bl_pairs, cfg_writes);
        $display("%0d result beats checked, %0d mismatches", outcome_count, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
